/* src/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, register codes and reset values for the button press
// classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

	localparam int CntW    = 16;
	localparam int CfgIdxW = 3;
	localparam int GestW   = 3;

	// register index codes
	localparam logic [CfgIdxW-1:0] RegClickMin    = 3'd0;
	localparam logic [CfgIdxW-1:0] RegClickMax    = 3'd1;
	localparam logic [CfgIdxW-1:0] RegLongMin     = 3'd2;
	localparam logic [CfgIdxW-1:0] RegLongMax     = 3'd3;
	localparam logic [CfgIdxW-1:0] RegVeryLongMin = 3'd4;
	localparam logic [CfgIdxW-1:0] RegVeryLongMax = 3'd5;
	localparam logic [CfgIdxW-1:0] RegIgnoreLimit = 3'd6;
	localparam logic [CfgIdxW-1:0] RegDoubleWin   = 3'd7;

	// register reset values
	localparam logic [CntW-1:0] ClickMinRst    = 16'd20;
	localparam logic [CntW-1:0] ClickMaxRst    = 16'd500;
	localparam logic [CntW-1:0] LongMinRst     = 16'd1000;
	localparam logic [CntW-1:0] LongMaxRst     = 16'd3000;
	localparam logic [CntW-1:0] VeryLongMinRst = 16'd4000;
	localparam logic [CntW-1:0] VeryLongMaxRst = 16'd8000;
	localparam logic [CntW-1:0] IgnoreLimitRst = 16'd10000;
	localparam logic [CntW-1:0] DoubleWinRst   = 16'd300;

	localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

	typedef enum logic [GestW-1:0] {
		GEST_NONE   = 3'd0,
		GEST_CLICK  = 3'd1,
		GEST_DOUBLE = 3'd2,
		GEST_LONG   = 3'd3,
		GEST_VLONG  = 3'd4
	} gesture_t;

	typedef struct packed {
		logic [CntW-1:0] click_min;
		logic [CntW-1:0] click_max;
		logic [CntW-1:0] long_min;
		logic [CntW-1:0] long_max;
		logic [CntW-1:0] very_long_min;
		logic [CntW-1:0] very_long_max;
		logic [CntW-1:0] ignore_limit;
		logic [CntW-1:0] double_window;
	} cfg_t;

endpackage

`default_nettype wire

/* src/bpc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// bpc_cfg_regs
// Threshold and window registers, written one word at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_cfg_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_en,
	input  wire logic [bpc_pkg::CfgIdxW-1:0]  wr_index,
	input  wire logic [bpc_pkg::CntW-1:0]     wr_data,
	output bpc_pkg::cfg_t                     cfg
);

	bpc_pkg::cfg_t cfg_q;

	// register file, one word per write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.click_min     <= bpc_pkg::ClickMinRst;
			cfg_q.click_max     <= bpc_pkg::ClickMaxRst;
			cfg_q.long_min      <= bpc_pkg::LongMinRst;
			cfg_q.long_max      <= bpc_pkg::LongMaxRst;
			cfg_q.very_long_min <= bpc_pkg::VeryLongMinRst;
			cfg_q.very_long_max <= bpc_pkg::VeryLongMaxRst;
			cfg_q.ignore_limit  <= bpc_pkg::IgnoreLimitRst;
			cfg_q.double_window <= bpc_pkg::DoubleWinRst;
		end else if (wr_en) begin
			case (wr_index)
				bpc_pkg::RegClickMin:    cfg_q.click_min     <= wr_data;
				bpc_pkg::RegClickMax:    cfg_q.click_max     <= wr_data;
				bpc_pkg::RegLongMin:     cfg_q.long_min      <= wr_data;
				bpc_pkg::RegLongMax:     cfg_q.long_max      <= wr_data;
				bpc_pkg::RegVeryLongMin: cfg_q.very_long_min <= wr_data;
				bpc_pkg::RegVeryLongMax: cfg_q.very_long_max <= wr_data;
				bpc_pkg::RegIgnoreLimit: cfg_q.ignore_limit  <= wr_data;
				bpc_pkg::RegDoubleWin:   cfg_q.double_window <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* src/bpc_classify.sv */
// ----------------------------------------------------------------------------
// bpc_classify
// Press tracking state and hold classification for one sample per step.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_classify (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic          level,
	input  wire bpc_pkg::cfg_t cfg,
	output bpc_pkg::gesture_t  gesture
);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HELD = 2'd1,
		PH_WAIT = 2'd2
	} phase_t;

	phase_t                    phase_q, phase_d, phase_e;
	logic                      last_level_q;
	logic [bpc_pkg::CntW-1:0]  hold_q, hold_d;
	logic [bpc_pkg::CntW-1:0]  since_q, since_d;
	logic                      in_click, in_long, in_vlong, over_limit;

	// counters count up first, then edges are applied
	always_comb begin
		since_d = (since_q == bpc_pkg::CntMax) ? since_q : since_q + 1'b1;
		hold_d  = hold_q;
		case (phase_q)
			PH_HELD, PH_WAIT: begin
				phase_e = phase_q;
				if (hold_q != bpc_pkg::CntMax) hold_d = hold_q + 1'b1;
			end
			default: phase_e = PH_IDLE;
		endcase
		if (level && !last_level_q) begin
			phase_e = PH_HELD;
			hold_d  = '0;
		end else if (!level && last_level_q) begin
			phase_e = PH_WAIT;
		end
	end

	// band compares on the updated hold count
	assign in_click   = (hold_d >= cfg.click_min) && (hold_d <= cfg.click_max);
	assign in_long    = (hold_d >= cfg.long_min) && (hold_d <= cfg.long_max);
	assign in_vlong   = (hold_d >= cfg.very_long_min) && (hold_d <= cfg.very_long_max);
	assign over_limit = (hold_d >= cfg.ignore_limit);

	// classification of a pending press, first matching band wins
	always_comb begin
		phase_d = phase_e;
		gesture = bpc_pkg::GEST_NONE;
		if (phase_e == PH_WAIT) begin
			if (in_click) begin
				phase_d = PH_IDLE;
				if (since_d <= cfg.double_window) begin
					gesture = bpc_pkg::GEST_DOUBLE;
				end else begin
					gesture = bpc_pkg::GEST_CLICK;
				end
			end else if (in_long) begin
				phase_d = PH_IDLE;
				gesture = bpc_pkg::GEST_LONG;
			end else if (in_vlong) begin
				phase_d = PH_IDLE;
				gesture = bpc_pkg::GEST_VLONG;
			end else if (over_limit) begin
				phase_d = PH_IDLE;
			end
		end
	end

	// state update once per sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			last_level_q <= 1'b0;
			hold_q       <= '0;
			since_q      <= bpc_pkg::CntMax;
		end else if (step) begin
			phase_q      <= phase_d;
			last_level_q <= level;
			hold_q       <= hold_d;
			since_q      <= (gesture == bpc_pkg::GEST_CLICK) ? '0 : since_d;
		end
	end

endmodule

`default_nettype wire

/* src/button_press_classifier.sv */
// ----------------------------------------------------------------------------
// button_press_classifier
// Click, double click, long and long-long press detector, one sample a tick.
// ----------------------------------------------------------------------------
// Every level word taken gives exactly one gesture word (input register, then
// result register); a gesture of zero means nothing happened on that tick. The
// sustained rate is one word per cycle while nothing stalls, set by the single
// classify step between the two registers. Stall on the result side backs up
// through the input register to the input stall. Write registers through the
// cfg port only while no word is in flight; the block does not enforce this.
`default_nettype none

module button_press_classifier (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output      logic                         in_stall,
	input  wire logic                         level,
	output      logic                         out_valid,
	input  wire logic                         out_stall,
	output      logic [bpc_pkg::GestW-1:0]    gesture,
	input  wire logic                         cfg_valid,
	output      logic                         cfg_ready,
	input  wire logic [bpc_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [bpc_pkg::CntW-1:0]     cfg_data
);

	bpc_pkg::cfg_t      cfg;
	bpc_pkg::gesture_t  gesture_d;
	logic               valid_s1, level_s1;
	logic               out_valid_q;
	logic [bpc_pkg::GestW-1:0] gesture_q;
	logic               advance;

	assign cfg_ready = 1'b1;

	bpc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// stage 1 word moves on when the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			level_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
			level_s1 <= level;
		end
	end

	bpc_classify u_classify (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.level   (level_s1),
		.cfg     (cfg),
		.gesture (gesture_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			gesture_q   <= '0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
			gesture_q   <= gesture_d;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign gesture   = gesture_q;

	// a stalled input means a full, stalled result register
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while result register could drain");

	// a word leaving stage 1 always lands in the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("classified word lost");

	// a taken result with nothing behind it empties the register
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !advance) |=> !out_valid)
		else $error("result word repeated");

endmodule

`default_nettype wire

/* verif/bpc_scoreboard_pkg.sv */
// ----------------------------------------------------------------------------
// bpc_scoreboard_pkg
// Gesture predictor and result scoreboard for the button press classifier.
// Every accepted level word is run through a cycle-free model of the
// classifier, and the expected gesture word is queued. Each gesture word that
// leaves the block is compared against the oldest queued one.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_scoreboard_pkg;

	import bpc_pkg::*;

	typedef enum logic [1:0] {
		PRESS_IDLE = 2'd0,
		PRESS_DOWN = 2'd1,
		PRESS_WAIT = 2'd2
	} press_phase_t;

	class gesture_scoreboard;

		cfg_t            cfg;
		press_phase_t    phase;
		bit              last_level;
		logic [CntW-1:0] hold_ticks;
		logic [CntW-1:0] since_click;
		gesture_t        gesture_q[$];
		int              failures;

		function new();
			cfg.click_min     = ClickMinRst;
			cfg.click_max     = ClickMaxRst;
			cfg.long_min      = LongMinRst;
			cfg.long_max      = LongMaxRst;
			cfg.very_long_min = VeryLongMinRst;
			cfg.very_long_max = VeryLongMaxRst;
			cfg.ignore_limit  = IgnoreLimitRst;
			cfg.double_window = DoubleWinRst;
			phase       = PRESS_IDLE;
			last_level  = 1'b0;
			hold_ticks  = '0;
			since_click = CntMax;
			failures    = 0;
		endfunction

		// register write as seen by the block
		function void write_reg(logic [CfgIdxW-1:0] idx, logic [CntW-1:0] data);
			case (idx)
				RegClickMin:    cfg.click_min     = data;
				RegClickMax:    cfg.click_max     = data;
				RegLongMin:     cfg.long_min      = data;
				RegLongMax:     cfg.long_max      = data;
				RegVeryLongMin: cfg.very_long_min = data;
				RegVeryLongMax: cfg.very_long_max = data;
				RegIgnoreLimit: cfg.ignore_limit  = data;
				RegDoubleWin:   cfg.double_window = data;
				default: ;
			endcase
		endfunction

		function logic [CntW-1:0] bump(logic [CntW-1:0] v);
			return (v == CntMax) ? v : v + 1'b1;
		endfunction

		function bit in_band(logic [CntW-1:0] v, logic [CntW-1:0] lo, logic [CntW-1:0] hi);
			return (v >= lo) && (v <= hi);
		endfunction

		// one tick: counters, then edges, then classification of a pending press
		function void note_level(bit lv);
			gesture_t g;
			g = GEST_NONE;
			since_click = bump(since_click);
			if (phase != PRESS_IDLE)
				hold_ticks = bump(hold_ticks);
			if (lv && !last_level) begin
				phase      = PRESS_DOWN;
				hold_ticks = '0;
			end else if (!lv && last_level) begin
				phase = PRESS_WAIT;
			end
			last_level = lv;

			// bands tried in fixed order, first match wins
			if (phase == PRESS_WAIT) begin
				if (in_band(hold_ticks, cfg.click_min, cfg.click_max)) begin
					if (since_click <= cfg.double_window) begin
						g = GEST_DOUBLE;
					end else begin
						g           = GEST_CLICK;
						since_click = '0;
					end
					phase = PRESS_IDLE;
				end else if (in_band(hold_ticks, cfg.long_min, cfg.long_max)) begin
					g     = GEST_LONG;
					phase = PRESS_IDLE;
				end else if (in_band(hold_ticks, cfg.very_long_min, cfg.very_long_max)) begin
					g     = GEST_VLONG;
					phase = PRESS_IDLE;
				end else if (hold_ticks >= cfg.ignore_limit) begin
					phase = PRESS_IDLE;
				end
			end
			gesture_q.push_back(g);
		endfunction

		function void check_gesture(logic [GestW-1:0] got);
			gesture_t want;
			if (gesture_q.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("error: gesture word %0d arrived with none outstanding", got);
				return;
			end
			want = gesture_q.pop_front();
			if (got !== want) begin
				failures++;
				if (failures <= 10)
					$display("mismatch: gesture expected %0d (%s), got %0d",
						want, want.name(), got);
			end
		endfunction

		function int pending();
			return gesture_q.size();
		endfunction

	endclass

endpackage

`default_nettype wire

/* verif/button_press_classifier_tb.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the button press classifier.
// Level words are streamed in as press and release sequences shaped around
// the programmed bands, under several register settings and idle patterns,
// and every gesture word is checked against the scoreboard's prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	import bpc_pkg::*;
	import bpc_scoreboard_pkg::*;

	typedef enum int {
		IDLE_NONE     = 0,
		IDLE_SENDER   = 1,
		IDLE_RECEIVER = 2,
		IDLE_BOTH     = 3
	} idle_mode_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               level     = 1'b0;
	logic               out_stall = 1'b0;
	logic               cfg_valid = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = RegClickMin;
	logic [CntW-1:0]    cfg_data  = '0;
	wire logic          in_stall;
	wire logic          out_valid;
	wire logic          cfg_ready;
	wire logic [GestW-1:0] gesture;

	idle_mode_t        idle_mode  = IDLE_NONE;
	bit                hold_off   = 1'b0;
	int                words_sent = 0;
	cfg_t              cur_cfg;
	gesture_scoreboard sb;

	button_press_classifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.level     (level),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.gesture   (gesture),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// result side: check accepted words, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_gesture(gesture);
		if (hold_off) begin
			out_stall <= 1'b1;
		end else begin
			case (idle_mode)
				IDLE_RECEIVER: out_stall <= ($urandom_range(0, 99) < 82);
				IDLE_BOTH:     out_stall <= ($urandom_range(0, 99) < 20);
				default:       out_stall <= 1'b0;
			endcase
		end
	end

	// run limit
	initial begin
		#(20 * 1000000);
		$display("FAILED: results differ");
		$finish;
	end

	function automatic bit sender_idles();
		case (idle_mode)
			IDLE_SENDER: return $urandom_range(0, 99) < 82;
			IDLE_BOTH:   return $urandom_range(0, 99) < 20;
			default:     return 1'b0;
		endcase
	endfunction

	// offer one level word and wait until it is taken
	task automatic send_level(input bit lv);
		if (sender_idles()) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (sender_idles());
		end
		in_valid <= 1'b1;
		level    <= lv;
		do @(posedge clk); while (in_stall);
		sb.note_level(lv);
		words_sent++;
	endtask

	task automatic send_press(input int high_len, input int low_len);
		repeat (high_len) send_level(1'b1);
		repeat (low_len) send_level(1'b0);
	endtask

	// stop offering and let every outstanding gesture come out
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CntW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	task automatic load_config(input cfg_t c);
		write_reg(RegClickMin, c.click_min);
		write_reg(RegClickMax, c.click_max);
		write_reg(RegLongMin, c.long_min);
		write_reg(RegLongMax, c.long_max);
		write_reg(RegVeryLongMin, c.very_long_min);
		write_reg(RegVeryLongMax, c.very_long_max);
		write_reg(RegIgnoreLimit, c.ignore_limit);
		write_reg(RegDoubleWin, c.double_window);
		cfg_valid <= 1'b0;
		cur_cfg = c;
	endtask

	// hold length aimed at a band edge most of the time
	function automatic int pick_hold(input int cap);
		int th[7];
		int k;
		int v;
		th = '{int'(cur_cfg.click_min), int'(cur_cfg.click_max), int'(cur_cfg.long_min),
			int'(cur_cfg.long_max), int'(cur_cfg.very_long_min),
			int'(cur_cfg.very_long_max), int'(cur_cfg.ignore_limit)};
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(1, cap);
		k = $urandom_range(0, 6);
		v = th[k] + int'($urandom_range(0, 2)) - 1;
		if (v < 1)
			v = 1;
		if (v > cap)
			v = cap;
		return v;
	endfunction

	// release length, sometimes spread across the double click window
	function automatic int pick_low();
		int span;
		span = (cur_cfg.double_window > 30) ? 32 : int'(cur_cfg.double_window) + 2;
		if ($urandom_range(0, 3) != 0)
			return $urandom_range(1, 3);
		return $urandom_range(1, span);
	endfunction

	// mostly clean presses, some random level noise
	task automatic run_gestures(input int budget);
		int start;
		start = words_sent;
		while (words_sent - start < budget) begin
			if ($urandom_range(0, 9) < 8)
				send_press(pick_hold(40), pick_low());
			else
				repeat ($urandom_range(1, 4)) send_level(1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		cfg_t cfg_tight;
		cfg_t cfg_short;
		cfg_t cfg_inverted;
		cfg_t cfg_overlap;
		cfg_t cfg_zero;
		cfg_t cfg_full;

		sb = new();
		cur_cfg = '{ClickMinRst, ClickMaxRst, LongMinRst, LongMaxRst,
			VeryLongMinRst, VeryLongMaxRst, IgnoreLimitRst, DoubleWinRst};
		cfg_tight    = '{16'd1, 16'd1, 16'd2, 16'd2, 16'd3, 16'd3, 16'd5, 16'd3};
		cfg_short    = '{16'd2, 16'd6, 16'd9, 16'd14, 16'd18, 16'd26, 16'd34, 16'd12};
		cfg_inverted = '{16'd8, 16'd3, 16'd1, 16'd4, 16'd6, 16'd9, 16'd12, 16'd5};
		cfg_overlap  = '{16'd10, 16'd20, 16'd0, 16'd15, 16'd12, 16'd30, 16'd25, CntMax};
		cfg_zero     = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
		cfg_full     = '{CntMax, CntMax, CntMax, CntMax, CntMax, CntMax, CntMax, 16'd0};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: hold of exactly the shortest click
		send_press(20, 1);
		drain();

		// one band per hold length, short double click window
		load_config(cfg_tight);
		send_press(1, 1);   // double click inside the window
		send_press(1, 1);   // click
		send_press(2, 1);   // long press
		send_press(3, 1);   // long-long press
		send_press(4, 2);   // gap, retried until ignored
		send_press(4, 1);   // gap left pending
		send_press(1, 1);   // new press drops the pending one, click
		drain();

		// receiver held off while words keep coming, then a sender pause
		idle_mode <= IDLE_NONE;
		load_config(cfg_short);
		fork
			begin
				hold_off <= 1'b1;
				repeat (60) @(posedge clk);
				hold_off <= 1'b0;
			end
		join_none
		run_gestures(40);
		drain();
		run_gestures(20);
		drain();

		// every idle pattern over two band layouts
		for (int m = IDLE_NONE; m <= IDLE_BOTH; m++) begin
			idle_mode <= idle_mode_t'(m);
			load_config(cfg_short);
			run_gestures(20);
			drain();
			load_config(cfg_inverted);
			run_gestures(20);
			drain();
		end

		// overlapping bands with an endless double click window
		idle_mode <= IDLE_BOTH;
		load_config(cfg_overlap);
		run_gestures(30);
		drain();

		// all registers zero: every press is ignored
		idle_mode <= IDLE_SENDER;
		load_config(cfg_zero);
		run_gestures(20);
		drain();

		// all registers at full scale: no band is reached, pending presses are dropped
		idle_mode <= IDLE_NONE;
		load_config(cfg_full);
		send_press(6, 3);
		send_press(2, 4);
		drain();

		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* sim.f */
src/bpc_pkg.sv
src/bpc_cfg_regs.sv
src/bpc_classify.sv
src/button_press_classifier.sv
verif/bpc_scoreboard_pkg.sv
verif/button_press_classifier_tb.sv
